[hw/rtl/psuv_pkg.sv]
`timescale 1ns / 1ps

package psuv_pkg;

  localparam int OBJECT_COUNT      = 64;
  localparam int WORDS_PER_BINDING = 16;
  localparam int OBJ_W             = 6;
  localparam int WORD_W            = 4;
  localparam int MID_W             = 40;
  localparam int OUT_W             = 37;
  localparam int LAST              = 12;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic signed [63:0] MID_MAX  = 64'sd549755813887;
  localparam logic signed [63:0] MID_MIN  = -64'sd549755813888;
  localparam logic signed [63:0] OUT_MAX  = 64'sd68719476735;
  localparam logic signed [63:0] OUT_MIN  = -64'sd68719476736;
  localparam logic signed [63:0] UV_BOUND = 64'sd65536000000;

  typedef struct packed {
    logic                    ovf;
    logic signed [MID_W-1:0] val;
  } sat_t;

  // Binding terms that travel down the pipeline with each hit.
  typedef struct packed {
    logic             live;
    logic             space;
    logic [2:0][47:0] rest_ax;
    logic [2:0][31:0] ratio;
    logic [2:0][31:0] map_org;
    logic [1:0][47:0] map_ax;
    logic [1:0][31:0] pivot;
    logic [1:0][31:0] offset;
    logic [1:0][31:0] rtile;
    logic [15:0]      cs;
    logic [15:0]      sn;
  } ctx_t;

  function automatic sat_t sat_mid(input logic signed [63:0] x);
    sat_t r;
    r.ovf = 1'b0;
    r.val = x[MID_W-1:0];
    if (x > MID_MAX) begin
      r.ovf = 1'b1;
      r.val = MID_MAX[MID_W-1:0];
    end else if (x < MID_MIN) begin
      r.ovf = 1'b1;
      r.val = MID_MIN[MID_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] p);
    return (p + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > OUT_MAX) y = OUT_MAX;
    if (x < OUT_MIN) y = OUT_MIN;
    return y[OUT_W-1:0];
  endfunction

endpackage

[hw/rtl/planar_surface_uv_mapper.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  cmd, object_index, pos_x/y/z, word_index, word_value
// out_      output     out_valid/out_stall  u_tiles, v_tiles, coords_valid
// cfg_      input      cfg_we               cfg_wdata (runtime scene enable)
//
// One transfer per cycle on the input while in_stall is low; a map command passes
// through the stage registers to the output register.
// The binding table is sixteen banks of 64 words read in parallel by object.
// After reset a clearing pass zeroes one object row per cycle through all 64 rows,
// during which in_stall stays high.
// A stall on the output while out_valid is high freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module planar_surface_uv_mapper import psuv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [OBJ_W-1:0]        in_object_index,
  input  logic signed [31:0]      in_pos_x,
  input  logic signed [31:0]      in_pos_y,
  input  logic signed [31:0]      in_pos_z,
  input  logic [WORD_W-1:0]       in_word_index,
  input  logic [63:0]             in_word_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_u_tiles,
  output logic signed [OUT_W-1:0] out_v_tiles,
  output logic                    out_coords_valid,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata
);

  // Control.
  logic             scene_en_r;
  logic             clearing_r;
  logic [OBJ_W-1:0] clr_idx_r;
  logic             adv;
  logic             accept;
  logic             hit_acc;
  logic             wr_en;
  logic             vld_r [LAST+1];
  logic             ovf_r [LAST+1];
  ctx_t             ctx_r [LAST+1];

  // Table and stage 0.
  logic [63:0]        bank_mem [WORDS_PER_BINDING][OBJECT_COUNT];
  logic [63:0]        rd_r [WORDS_PER_BINDING];
  logic signed [31:0] pos0_r [3];
  logic               en0_r;
  ctx_t               ctx0;

  // Stage data.
  logic signed [32:0]      d_nxt [3], d1_r [3];
  logic signed [63:0]      pw_nxt [3], pw1_r [3];
  logic signed [48:0]      rp_nxt [3][3], rp2_r [3][3];
  logic signed [MID_W-1:0] wpt_nxt [3], wpt2_r [3], wpt3_r [3], wpt4_r [3];
  logic signed [MID_W-1:0] dot_nxt [3], dot3_r [3];
  logic signed [56:0]      rl_nxt [3], rl4_r [3];
  logic signed [55:0]      rh_nxt [3], rh4_r [3];
  logic signed [MID_W-1:0] pt_nxt [3], pt5_r [3];
  logic signed [MID_W-1:0] q_nxt [3], q6_r [3];
  logic signed [55:0]      mp_nxt [2][3], mp7_r [2][3];
  logic signed [MID_W-1:0] uv_nxt [2], uv8_r [2];
  logic signed [55:0]      rot_nxt [4], rot9_r [4];
  logic signed [MID_W-1:0] rr_nxt [2], rr10_r [2];
  logic signed [56:0]      tl_nxt [2], tl11_r [2];
  logic signed [55:0]      th_nxt [2], th11_r [2];
  logic [OUT_W-1:0]        u_nxt, v_nxt, u_r, v_r;
  logic                    cv_nxt, cv_r;
  logic                    f2, f3, f5, f6, f8, f10;

  // The whole pipeline moves together whenever the output register can take data.
  assign adv      = !vld_r[LAST] || !out_stall;
  assign in_stall = !adv || clearing_r;
  assign accept   = in_valid && !in_stall;
  assign hit_acc  = accept && (in_cmd == CMD_MAP);
  assign wr_en    = accept && (in_cmd == CMD_WRITE) && (int'(in_object_index) < OBJECT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scene_en_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      if (cfg_we) scene_en_r <= cfg_wdata;
      if (clearing_r) begin
        if (clr_idx_r == OBJ_W'(OBJECT_COUNT - 1)) clearing_r <= 1'b0;
        else clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // One bank per binding word, so a hit reads all words of its binding in parallel.
  for (genvar b = 0; b < WORDS_PER_BINDING; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (clearing_r) begin
        bank_mem[b][clr_idx_r] <= '0;
      end else if (wr_en && (in_word_index == WORD_W'(b))) begin
        bank_mem[b][in_object_index] <= in_word_value;
      end
      if (adv) rd_r[b] <= bank_mem[b][in_object_index];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos0_r[0] <= in_pos_x;
      pos0_r[1] <= in_pos_y;
      pos0_r[2] <= in_pos_z;
      en0_r     <= scene_en_r && (int'(in_object_index) < OBJECT_COUNT);
    end
  end

  always_comb begin
    ctx0.live       = en0_r & rd_r[0][0];
    ctx0.space      = rd_r[0][1];
    ctx0.rest_ax[0] = rd_r[10][47:0];
    ctx0.rest_ax[1] = rd_r[11][47:0];
    ctx0.rest_ax[2] = rd_r[12][47:0];
    ctx0.ratio[0]   = rd_r[3][31:0];
    ctx0.ratio[1]   = rd_r[3][63:32];
    ctx0.ratio[2]   = rd_r[4][31:0];
    ctx0.map_org[0] = rd_r[5][31:0];
    ctx0.map_org[1] = rd_r[5][63:32];
    ctx0.map_org[2] = rd_r[6][31:0];
    ctx0.map_ax[0]  = rd_r[13][47:0];
    ctx0.map_ax[1]  = rd_r[14][47:0];
    ctx0.pivot[0]   = rd_r[7][31:0];
    ctx0.pivot[1]   = rd_r[7][63:32];
    ctx0.offset[0]  = rd_r[8][31:0];
    ctx0.offset[1]  = rd_r[8][63:32];
    ctx0.rtile[0]   = rd_r[9][31:0];
    ctx0.rtile[1]   = rd_r[9][63:32];
    ctx0.cs         = rd_r[15][15:0];
    ctx0.sn         = rd_r[15][31:16];
  end

  // Stage 1: offset from the rest origin, and the world-scale product.
  always_comb begin
    d_nxt[0]  = 33'(pos0_r[0]) - 33'($signed(rd_r[1][31:0]));
    d_nxt[1]  = 33'(pos0_r[1]) - 33'($signed(rd_r[1][63:32]));
    d_nxt[2]  = 33'(pos0_r[2]) - 33'($signed(rd_r[2][31:0]));
    for (int k = 0; k < 3; k++) pw_nxt[k] = pos0_r[k] * $signed(rd_r[2][63:32]);
  end

  // Stage 2: rest-axis products; world point rounded and saturated.
  always_comb begin
    sat_t s;
    f2 = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        rp_nxt[j][k] = d1_r[k] * $signed(ctx_r[1].rest_ax[j][k*16 +: 16]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      s          = sat_mid(rnd_q16(pw1_r[k]));
      wpt_nxt[k] = s.val;
      f2         = f2 | (s.ovf & !ctx_r[1].space);
    end
  end

  // Stage 3: rest-frame dot products.
  always_comb begin
    sat_t s;
    f3 = 1'b0;
    for (int j = 0; j < 3; j++) begin
      s = sat_mid(rnd_q14(64'(rp2_r[j][0])) + rnd_q14(64'(rp2_r[j][1])) +
                  rnd_q14(64'(rp2_r[j][2])));
      dot_nxt[j] = s.val;
      f3         = f3 | (s.ovf & ctx_r[2].space);
    end
  end

  // Stage 4: size-ratio products, split in low and high halves of the ratio.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rl_nxt[j] = dot3_r[j] * $signed({1'b0, ctx_r[3].ratio[j][15:0]});
      rh_nxt[j] = dot3_r[j] * $signed(ctx_r[3].ratio[j][31:16]);
    end
  end

  // Stage 5: projected point from the selected space.
  always_comb begin
    sat_t s;
    f5 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      s = sat_mid(64'(rh4_r[k]) + rnd_q16(64'(rl4_r[k])));
      if (ctx_r[4].space) begin
        pt_nxt[k] = s.val;
        f5        = f5 | s.ovf;
      end else begin
        pt_nxt[k] = wpt4_r[k];
      end
    end
  end

  // Stage 6: relative to the map origin.
  always_comb begin
    sat_t s;
    f6 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      s        = sat_mid(64'(pt5_r[k]) - 64'($signed(ctx_r[5].map_org[k])));
      q_nxt[k] = s.val;
      f6       = f6 | s.ovf;
    end
  end

  // Stage 7: map-axis products.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        mp_nxt[j][k] = q6_r[k] * $signed(ctx_r[6].map_ax[j][k*16 +: 16]);
      end
    end
  end

  // Stage 8: map coordinates relative to the pivot.
  always_comb begin
    sat_t s, t;
    f8 = 1'b0;
    for (int j = 0; j < 2; j++) begin
      s = sat_mid(rnd_q14(64'(mp7_r[j][0])) + rnd_q14(64'(mp7_r[j][1])) +
                  rnd_q14(64'(mp7_r[j][2])));
      t = sat_mid(64'(s.val) - 64'($signed(ctx_r[7].pivot[j])));
      uv_nxt[j] = t.val;
      f8        = f8 | s.ovf | t.ovf;
    end
  end

  // Stage 9: rotation products.
  always_comb begin
    rot_nxt[0] = uv8_r[0] * $signed(ctx_r[8].cs);
    rot_nxt[1] = uv8_r[1] * $signed(ctx_r[8].sn);
    rot_nxt[2] = uv8_r[0] * $signed(ctx_r[8].sn);
    rot_nxt[3] = uv8_r[1] * $signed(ctx_r[8].cs);
  end

  // Stage 10: rotate back about the pivot and apply the offset.
  always_comb begin
    sat_t s, t;
    s = sat_mid(rnd_q14(64'(rot9_r[0])) - rnd_q14(64'(rot9_r[1])) +
                64'($signed(ctx_r[9].pivot[0])) + 64'($signed(ctx_r[9].offset[0])));
    t = sat_mid(rnd_q14(64'(rot9_r[2])) + rnd_q14(64'(rot9_r[3])) +
                64'($signed(ctx_r[9].pivot[1])) + 64'($signed(ctx_r[9].offset[1])));
    rr_nxt[0] = s.val;
    rr_nxt[1] = t.val;
    f10       = s.ovf | t.ovf;
  end

  // Stage 11: tile scaling products.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      tl_nxt[j] = rr10_r[j] * $signed({1'b0, ctx_r[10].rtile[j][15:0]});
      th_nxt[j] = rr10_r[j] * $signed(ctx_r[10].rtile[j][31:16]);
    end
  end

  // Stage 12: final tiles, clamp and validity.
  always_comb begin
    logic signed [63:0] tu, tv;
    tu     = 64'(th11_r[0]) + rnd_q16(64'(tl11_r[0]));
    tv     = 64'(th11_r[1]) + rnd_q16(64'(tl11_r[1]));
    u_nxt  = '0;
    v_nxt  = '0;
    cv_nxt = 1'b0;
    if (ctx_r[11].live) begin
      u_nxt  = clamp_out(tu);
      v_nxt  = clamp_out(tv);
      cv_nxt = !ovf_r[11] && (tu < UV_BOUND) && (tu > -UV_BOUND) &&
               (tv < UV_BOUND) && (tv > -UV_BOUND);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= hit_acc;
      for (int k = 1; k <= LAST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[0] <= ctx0;
      ctx_r[1] <= ctx0;
      for (int k = 2; k <= LAST; k++) ctx_r[k] <= ctx_r[k-1];
      ovf_r[0]  <= 1'b0;
      ovf_r[1]  <= 1'b0;
      ovf_r[2]  <= ovf_r[1] | f2;
      ovf_r[3]  <= ovf_r[2] | f3;
      ovf_r[4]  <= ovf_r[3];
      ovf_r[5]  <= ovf_r[4] | f5;
      ovf_r[6]  <= ovf_r[5] | f6;
      ovf_r[7]  <= ovf_r[6];
      ovf_r[8]  <= ovf_r[7] | f8;
      ovf_r[9]  <= ovf_r[8];
      ovf_r[10] <= ovf_r[9] | f10;
      ovf_r[11] <= ovf_r[10];
      ovf_r[12] <= ovf_r[11];
      d1_r   <= d_nxt;
      pw1_r  <= pw_nxt;
      rp2_r  <= rp_nxt;
      wpt2_r <= wpt_nxt;
      wpt3_r <= wpt2_r;
      wpt4_r <= wpt3_r;
      dot3_r <= dot_nxt;
      rl4_r  <= rl_nxt;
      rh4_r  <= rh_nxt;
      pt5_r  <= pt_nxt;
      q6_r   <= q_nxt;
      mp7_r  <= mp_nxt;
      uv8_r  <= uv_nxt;
      rot9_r <= rot_nxt;
      rr10_r <= rr_nxt;
      tl11_r <= tl_nxt;
      th11_r <= th_nxt;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      cv_r   <= cv_nxt;
    end
  end

  assign out_valid        = vld_r[LAST];
  assign out_u_tiles      = u_r;
  assign out_v_tiles      = v_r;
  assign out_coords_valid = cv_r;

  // No transfer is taken while the table is being cleared.
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> in_stall) else $error("input taken during clearing pass");

  // A frozen pipeline keeps its first stage.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (vld_r[1] == $past(vld_r[1]))) else $error("pipeline moved while stalled");

  // Valid coordinates are never clamped values.
  a_valid_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coords_valid) |->
      (out_u_tiles != OUT_MAX[OUT_W-1:0] && out_u_tiles != OUT_MIN[OUT_W-1:0] &&
       out_v_tiles != OUT_MAX[OUT_W-1:0] && out_v_tiles != OUT_MIN[OUT_W-1:0]))
    else $error("clamped coordinates flagged valid");

endmodule
